// ===== rtl/line_pixel_rasterizer_unit_macros.svh =====
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_PIXEL_RASTERIZER_UNIT_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer assertion failed");

// Next-cycle implication, disabled during reset.
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer assertion failed");

`endif

// ===== rtl/lpr_pkg.sv =====
// Package with shared types and constants of the line rasterizer.
`timescale 1ns / 1ps
package lpr_pkg;

    localparam int COORD_W = 6;
    localparam int DIM_W   = 7;
    localparam int ERR_W   = 9;
    localparam int IN_W    = 8;
    localparam int COLOR_W = 32;
    localparam int INDEX_W = 1;

    localparam logic [INDEX_W-1:0] REG_BITMAP_WIDTH  = 1'b0;
    localparam logic [INDEX_W-1:0] REG_BITMAP_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic line_ok;
        logic out_free;
        logic at_last;
    } status_t;

endpackage

// ===== rtl/line_pixel_rasterizer_unit.sv =====
// Top level of the line rasterizer: controller and datapath.
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     start_x start_y end_x end_y colour
//  out       output     out_valid / out_stall   pixel_x pixel_y pixel_colour last_pixel
//  cfg       input      cfg_we                  cfg_index cfg_data
//
//  A line of n pixels, at most MAX_DIM, is accepted and then stepped n times.
//  The Bresenham stepper makes one pixel per unstalled cycle into a single output register.
//  A line with an endpoint outside the bitmap is dropped in its accept cycle.
//  A stall on out holds the stepper; in is stalled until the last pixel is stepped.
//  Reset restores both bitmap dimensions to 64 and empties the output register.
`timescale 1ns / 1ps
module line_pixel_rasterizer_unit
#(
    parameter int MAX_DIM = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lpr_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [lpr_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lpr_pkg::IN_W-1:0]     start_x,
    input  logic signed [lpr_pkg::IN_W-1:0]     start_y,
    input  logic signed [lpr_pkg::IN_W-1:0]     end_x,
    input  logic signed [lpr_pkg::IN_W-1:0]     end_y,
    input  logic [lpr_pkg::COLOR_W-1:0]         colour,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lpr_pkg::COORD_W-1:0]         pixel_x,
    output logic [lpr_pkg::COORD_W-1:0]         pixel_y,
    output logic [lpr_pkg::COLOR_W-1:0]         pixel_colour,
    output logic                                last_pixel
);

    lpr_pkg::cmd_t    cmd;
    lpr_pkg::status_t status;

    lpr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lpr_datapath
    #(
        .MAX_DIM (MAX_DIM)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .colour       (colour),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .last_pixel   (last_pixel)
    );

endmodule

// ===== rtl/lpr_ctrl.sv =====
// Controller state machine of the line rasterizer.
`timescale 1ns / 1ps
`include "line_pixel_rasterizer_unit_macros.svh"
module lpr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  lpr_pkg::status_t status,
    output lpr_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && status.line_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LPR_ASSERT_NEXT(a_load_runs, clk, rst_n, cmd.load, state_reg == ST_RUN)
    `LPR_ASSERT_NEXT(a_last_idles, clk, rst_n, cmd.step && status.at_last, state_reg == ST_IDLE)

endmodule

// ===== rtl/lpr_datapath.sv =====
// Datapath of the line rasterizer: registers, setup, Bresenham stepper, output stage.
`timescale 1ns / 1ps
`include "line_pixel_rasterizer_unit_macros.svh"
module lpr_datapath
#(
    parameter int MAX_DIM = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lpr_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [lpr_pkg::DIM_W-1:0]           cfg_data,
    input  logic signed [lpr_pkg::IN_W-1:0]     start_x,
    input  logic signed [lpr_pkg::IN_W-1:0]     start_y,
    input  logic signed [lpr_pkg::IN_W-1:0]     end_x,
    input  logic signed [lpr_pkg::IN_W-1:0]     end_y,
    input  logic [lpr_pkg::COLOR_W-1:0]         colour,
    input  lpr_pkg::cmd_t                       cmd,
    output lpr_pkg::status_t                    status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lpr_pkg::COORD_W-1:0]         pixel_x,
    output logic [lpr_pkg::COORD_W-1:0]         pixel_y,
    output logic [lpr_pkg::COLOR_W-1:0]         pixel_colour,
    output logic                                last_pixel
);

    localparam int CW = lpr_pkg::COORD_W;
    localparam int DW = lpr_pkg::DIM_W;
    localparam int EW = lpr_pkg::ERR_W;
    localparam logic [DW-1:0] MAX_DIM_V = DW'(MAX_DIM);

    logic [DW-1:0] width_reg, width_next;
    logic [DW-1:0] height_reg, height_next;
    logic [DW-1:0] eff_w, eff_h;

    logic [CW-1:0] xs, ys, xe, ye, dx, dy;
    logic          x_major, swap;
    logic [CW-1:0] maj_start, maj_end, min_start, min_end, dmaj, dmin;

    logic [CW-1:0] maj_reg, maj_next;
    logic [CW-1:0] maj_end_reg, maj_end_next;
    logic [CW-1:0] min_reg, min_next;
    logic [EW-1:0] e_reg, e_next;
    logic [DW-1:0] dmin2_reg, dmin2_next;
    logic [DW-1:0] dmaj2_reg, dmaj2_next;
    logic          x_major_reg, x_major_next;
    logic          min_up_reg, min_up_next;
    logic [lpr_pkg::COLOR_W-1:0] colour_reg, colour_next;
    logic [EW-1:0] e_sum;

    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] pixel_x_reg, pixel_x_next;
    logic [CW-1:0] pixel_y_reg, pixel_y_next;
    logic [lpr_pkg::COLOR_W-1:0] pixel_colour_reg, pixel_colour_next;
    logic          last_pixel_reg, last_pixel_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lpr_pkg::REG_BITMAP_WIDTH:  width_next  = cfg_data;
                lpr_pkg::REG_BITMAP_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_w = (width_reg  > MAX_DIM_V) ? MAX_DIM_V : width_reg;
    assign eff_h = (height_reg > MAX_DIM_V) ? MAX_DIM_V : height_reg;

    assign status.line_ok = !start_x[lpr_pkg::IN_W-1] && (start_x[DW-1:0] < eff_w)
                         && !start_y[lpr_pkg::IN_W-1] && (start_y[DW-1:0] < eff_h)
                         && !end_x[lpr_pkg::IN_W-1]   && (end_x[DW-1:0] < eff_w)
                         && !end_y[lpr_pkg::IN_W-1]   && (end_y[DW-1:0] < eff_h);

    assign xs = start_x[CW-1:0];
    assign ys = start_y[CW-1:0];
    assign xe = end_x[CW-1:0];
    assign ye = end_y[CW-1:0];

    assign dx      = (xe > xs) ? (xe - xs) : (xs - xe);
    assign dy      = (ye > ys) ? (ye - ys) : (ys - ye);
    assign x_major = dx > dy;
    assign swap    = x_major ? (xe < xs) : (ye < ys);

    always_comb
    begin
        if (x_major)
        begin
            maj_start = swap ? xe : xs;
            maj_end   = swap ? xs : xe;
            min_start = swap ? ye : ys;
            min_end   = swap ? ys : ye;
            dmaj      = dx;
            dmin      = dy;
        end
        else
        begin
            maj_start = swap ? ye : ys;
            maj_end   = swap ? ys : ye;
            min_start = swap ? xe : xs;
            min_end   = swap ? xs : xe;
            dmaj      = dy;
            dmin      = dx;
        end
    end

    assign e_sum           = e_reg + EW'(dmin2_reg);
    assign status.at_last  = maj_reg == maj_end_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        maj_next     = maj_reg;
        maj_end_next = maj_end_reg;
        min_next     = min_reg;
        e_next       = e_reg;
        dmin2_next   = dmin2_reg;
        dmaj2_next   = dmaj2_reg;
        x_major_next = x_major_reg;
        min_up_next  = min_up_reg;
        colour_next  = colour_reg;
        if (cmd.load)
        begin
            maj_next     = maj_start;
            maj_end_next = maj_end;
            min_next     = min_start;
            e_next       = EW'(dmin);
            dmin2_next   = {dmin, 1'b0};
            dmaj2_next   = {dmaj, 1'b0};
            x_major_next = x_major;
            min_up_next  = min_start < min_end;
            colour_next  = colour;
        end
        else if (cmd.step)
        begin
            maj_next = maj_reg + CW'(1);
            if (e_sum >= EW'(dmaj2_reg))
            begin
                e_next   = e_sum - EW'(dmaj2_reg);
                min_next = min_up_reg ? (min_reg + CW'(1)) : (min_reg - CW'(1));
            end
            else
            begin
                e_next = e_sum;
            end
        end
    end

    always_comb
    begin
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        pixel_colour_next = pixel_colour_reg;
        last_pixel_next   = last_pixel_reg;
        out_valid_next    = out_valid_reg && out_stall;
        if (cmd.step)
        begin
            out_valid_next    = 1'b1;
            pixel_x_next      = x_major_reg ? maj_reg : min_reg;
            pixel_y_next      = x_major_reg ? min_reg : maj_reg;
            pixel_colour_next = colour_reg;
            last_pixel_next   = status.at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= lpr_pkg::DIM_RESET;
            height_reg    <= lpr_pkg::DIM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        maj_reg          <= maj_next;
        maj_end_reg      <= maj_end_next;
        min_reg          <= min_next;
        e_reg            <= e_next;
        dmin2_reg        <= dmin2_next;
        dmaj2_reg        <= dmaj2_next;
        x_major_reg      <= x_major_next;
        min_up_reg       <= min_up_next;
        colour_reg       <= colour_next;
        pixel_x_reg      <= pixel_x_next;
        pixel_y_reg      <= pixel_y_next;
        pixel_colour_reg <= pixel_colour_next;
        last_pixel_reg   <= last_pixel_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_colour = pixel_colour_reg;
    assign last_pixel   = last_pixel_reg;

    `LPR_ASSERT_NOW(a_step_in_span, clk, rst_n, cmd.step, maj_reg <= maj_end_reg)
    `LPR_ASSERT_NOW(a_err_bounded, clk, rst_n, cmd.step, e_reg <= EW'(dmaj2_reg))

endmodule

// ===== tb/line_pixel_rasterizer_unit_tb.sv =====
// Self-checking testbench: directed lines, bitmap limits, random lines, no-idle runs, backpressure.
`timescale 1ns / 1ps
module line_pixel_rasterizer_unit_tb;

    localparam int COORD_W      = lpr_pkg::COORD_W;
    localparam int COLOR_W      = lpr_pkg::COLOR_W;
    localparam int DIM_W        = lpr_pkg::DIM_W;
    localparam int IN_W         = lpr_pkg::IN_W;
    localparam int INDEX_W      = lpr_pkg::INDEX_W;
    localparam int MAX_DIM      = 64;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_OFF_LEN = 400;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] colour;
        logic               last;
    } pixel_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [INDEX_W-1:0]        cfg_index = lpr_pkg::REG_BITMAP_WIDTH;
    logic [DIM_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [IN_W-1:0]    start_x = '0;
    logic signed [IN_W-1:0]    start_y = '0;
    logic signed [IN_W-1:0]    end_x = '0;
    logic signed [IN_W-1:0]    end_y = '0;
    logic [COLOR_W-1:0]        colour = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [COORD_W-1:0]        pixel_x;
    logic [COORD_W-1:0]        pixel_y;
    logic [COLOR_W-1:0]        pixel_colour;
    logic                      last_pixel;

    pixel_t            pending_pixels[$];
    logic [DIM_W-1:0]  width_setting = lpr_pkg::DIM_RESET;
    logic [DIM_W-1:0]  height_setting = lpr_pkg::DIM_RESET;
    int                tx_idle_pct = IDLE_PCT;
    int                rx_idle_pct = IDLE_PCT;
    logic              hold_off_req = 1'b0;
    int                hold_off_count = 0;
    int                fail_count = 0;
    int                cycle_count = 0;

    line_pixel_rasterizer_unit #(.MAX_DIM(MAX_DIM)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .colour       (colour),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .last_pixel   (last_pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: long hold-off once requested, random stalls otherwise.
    always @(negedge clk)
    begin
        if (hold_off_req && hold_off_count < HOLD_OFF_LEN)
        begin
            out_stall <= 1'b1;
            hold_off_count++;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel x=%0d y=%0d colour=%h last=%b",
                       pixel_x, pixel_y, pixel_colour, last_pixel);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_x !== want.x)
                begin
                    $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
                    fail_count++;
                end
                if (pixel_y !== want.y)
                begin
                    $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
                    fail_count++;
                end
                if (pixel_colour !== want.colour)
                begin
                    $error("pixel_colour: expected %h, got %h", want.colour, pixel_colour);
                    fail_count++;
                end
                if (last_pixel !== want.last)
                begin
                    $error("last_pixel: expected %b, got %b", want.last, last_pixel);
                    fail_count++;
                end
            end
        end
    end

    function automatic int clamp_dim(logic [DIM_W-1:0] setting);
        return (int'(setting) > MAX_DIM) ? MAX_DIM : int'(setting);
    endfunction

    function automatic void queue_pixel(int x, int y, logic [COLOR_W-1:0] col, logic last);
        pixel_t px;
        px.x = COORD_W'(x);
        px.y = COORD_W'(y);
        px.colour = col;
        px.last = last;
        pending_pixels.push_back(px);
    endfunction

    // Bresenham walk along the major axis; ties go to y.
    function automatic void rasterize_line(int xs, int ys, int xe, int ye,
                                           logic [COLOR_W-1:0] col);
        int w, h, dx, dy, err, dir, t, x, y;
        w = clamp_dim(width_setting);
        h = clamp_dim(height_setting);
        if (xs < 0 || ys < 0 || xe < 0 || ye < 0 ||
            xs >= w || xe >= w || ys >= h || ye >= h)
            return;
        if (xs == xe)
        begin
            if (ye < ys)
            begin
                t = ys; ys = ye; ye = t;
            end
            for (y = ys; y <= ye; y++)
                queue_pixel(xs, y, col, y == ye);
        end
        else if (ys == ye)
        begin
            if (xe < xs)
            begin
                t = xs; xs = xe; xe = t;
            end
            for (x = xs; x <= xe; x++)
                queue_pixel(x, ys, col, x == xe);
        end
        else
        begin
            dx = (xe > xs) ? xe - xs : xs - xe;
            dy = (ye > ys) ? ye - ys : ys - ye;
            if (dx > dy)
            begin
                if (xe < xs)
                begin
                    t = xs; xs = xe; xe = t;
                    t = ys; ys = ye; ye = t;
                end
                dir = (ys < ye) ? 1 : -1;
                err = dy;
                y = ys;
                for (x = xs; x <= xe; x++)
                begin
                    queue_pixel(x, y, col, x == xe);
                    err += 2 * dy;
                    if (err >= 2 * dx)
                    begin
                        err -= 2 * dx;
                        y += dir;
                    end
                end
            end
            else
            begin
                if (ye < ys)
                begin
                    t = xs; xs = xe; xe = t;
                    t = ys; ys = ye; ye = t;
                end
                dir = (xs < xe) ? 1 : -1;
                err = dx;
                x = xs;
                for (y = ys; y <= ye; y++)
                begin
                    queue_pixel(x, y, col, y == ye);
                    err += 2 * dx;
                    if (err >= 2 * dy)
                    begin
                        err -= 2 * dy;
                        x += dir;
                    end
                end
            end
        end
    endfunction

    task automatic send_line(input logic signed [IN_W-1:0] sx, input logic signed [IN_W-1:0] sy,
                             input logic signed [IN_W-1:0] ex, input logic signed [IN_W-1:0] ey,
                             input logic [COLOR_W-1:0] col);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        colour   <= col;
        do
            @(posedge clk);
        while (in_stall);
        rasterize_line(int'(sx), int'(sy), int'(ex), int'(ey), col);
        @(negedge clk);
    endtask

    task automatic drain_lines();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (MAX_DIM + 4) @(negedge clk);
    endtask

    task automatic set_dimension(input logic [INDEX_W-1:0] idx, input logic [DIM_W-1:0] value);
        drain_lines();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == lpr_pkg::REG_BITMAP_WIDTH)
            width_setting = value;
        else
            height_setting = value;
    endtask

    function automatic logic signed [IN_W-1:0] pick_coord(int dim);
        if (dim == 0 || $urandom_range(99) < 12)
            return IN_W'($urandom);
        return IN_W'($urandom_range(dim - 1));
    endfunction

    task automatic send_random_line();
        logic signed [IN_W-1:0] sx, sy, ex, ey;
        int w, h, shape;
        w = clamp_dim(width_setting);
        h = clamp_dim(height_setting);
        sx = pick_coord(w);
        sy = pick_coord(h);
        ex = pick_coord(w);
        ey = pick_coord(h);
        shape = $urandom_range(99);
        if (shape < 15)
            ex = sx;
        else if (shape < 30)
            ey = sy;
        else if (shape < 35)
        begin
            ex = sx;
            ey = sy;
        end
        send_line(sx, sy, ex, ey, $urandom);
    endtask

    task automatic test_directed_lines();
        send_line(0, 0, 0, 0, 32'h0000_0000);
        send_line(63, 63, 63, 63, 32'hFFFF_FFFF);
        send_line(5, 40, 5, 3, 32'h1234_5678);
        send_line(0, 0, 0, 63, 32'hA5A5_A5A5);
        send_line(63, 10, 0, 10, 32'h5A5A_5A5A);
        send_line(0, 63, 63, 63, 32'hFFFF_FFFF);
        send_line(50, 20, 3, 7, 32'h0F0F_0F0F);
        send_line(3, 7, 50, 20, 32'hF0F0_F0F0);
        send_line(10, 60, 30, 2, 32'h8000_0001);
        send_line(0, 0, 63, 63, 32'h7FFF_FFFE);
        send_line(63, 0, 0, 63, 32'hDEAD_BEEF);
        send_line(0, 62, 63, 1, 32'h0000_0001);
        send_line(1, 0, 2, 63, 32'h8000_0000);
        send_line(-1, 0, 5, 5, 32'h1111_1111);
        send_line(0, 64, 1, 1, 32'h2222_2222);
        send_line(5, 5, 64, 0, 32'h3333_3333);
        send_line(5, 5, 6, -1, 32'h4444_4444);
        send_line(-128, 127, 127, -128, 32'h5555_5555);
        send_line(127, 127, -128, -128, 32'h6666_6666);
        send_line(20, 30, 21, 31, 32'h7777_7777);
    endtask

    task automatic test_dimension_limits();
        set_dimension(lpr_pkg::REG_BITMAP_WIDTH, 7'd0);
        send_line(0, 0, 0, 0, 32'hCAFE_0000);
        send_line(0, 3, 0, 9, 32'hCAFE_0001);
        set_dimension(lpr_pkg::REG_BITMAP_WIDTH, 7'd1);
        set_dimension(lpr_pkg::REG_BITMAP_HEIGHT, 7'd1);
        send_line(0, 0, 0, 0, 32'hCAFE_0002);
        send_line(0, 0, 0, 1, 32'hCAFE_0003);
        send_line(1, 0, 0, 0, 32'hCAFE_0004);
        set_dimension(lpr_pkg::REG_BITMAP_WIDTH, 7'd127);
        set_dimension(lpr_pkg::REG_BITMAP_HEIGHT, 7'd65);
        send_line(63, 63, 0, 0, 32'hCAFE_0005);
        send_line(64, 0, 0, 0, 32'hCAFE_0006);
        send_line(0, 0, 0, 64, 32'hCAFE_0007);
    endtask

    task automatic test_random_lines();
        int widths[7]  = '{64, 127, 1, 64, 23, 2, 40};
        int heights[7] = '{64, 96, 64, 1, 9, 3, 64};
        for (int p = 0; p < 7; p++)
        begin
            set_dimension(lpr_pkg::REG_BITMAP_WIDTH, DIM_W'(widths[p]));
            set_dimension(lpr_pkg::REG_BITMAP_HEIGHT, DIM_W'(heights[p]));
            repeat (20) send_random_line();
        end
    endtask

    task automatic test_no_idle_stretch();
        set_dimension(lpr_pkg::REG_BITMAP_WIDTH, 7'd64);
        set_dimension(lpr_pkg::REG_BITMAP_HEIGHT, 7'd64);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (30) send_random_line();
        drain_lines();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        send_line(0, 0, 40, 12, 32'hB00B_0001);
        send_line(5, 60, 5, 10, 32'hB00B_0002);
        send_line(63, 0, 20, 0, 32'hB00B_0003);
        send_line(30, 2, 10, 50, 32'hB00B_0004);
        send_line(7, 7, 7, 7, 32'hB00B_0005);
        send_line(0, 63, 63, 0, 32'hB00B_0006);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_lines();
        test_dimension_limits();
        test_random_lines();
        test_no_idle_stretch();
        test_backpressure();
        drain_lines();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
